// ===== hdl/sfb_pkg.sv =====
// sfb_pkg: shared types, constants and the crc-8 step for the frame builder
// no dependencies
package sfb_pkg;

  localparam int MaxSlots = 6;
  localparam int QDepth = 4;
  localparam logic [7:0] CrcPoly = 8'h8C;
  localparam logic [7:0] CrcInit = 8'h00;
  localparam logic signed [11:0] LowLimit = 12'sd160;
  localparam logic signed [11:0] HighLimit = 12'sd1600;

  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindValue  = 2'd1,
    KindCrc    = 2'd2
  } byte_kind_t;

  typedef enum logic {
    CmdStart = 1'b0,
    CmdSlot  = 1'b1
  } cmd_t;

  // one queued job: a header or value byte, optionally followed by the crc byte
  typedef struct packed {
    logic [7:0] first_byte;
    byte_kind_t first_kind;
    logic       has_crc;
    logic [7:0] crc_byte;
  } job_t;

  // reflected crc-8, data fed lsb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    c = crc_in;
    d = data;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

// ===== hdl/sfb_front.sv =====
// sfb_front: takes requests, tracks the open frame, converts readings, updates the crc
// depends on sfb_pkg
module sfb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_sensor_count,
  input  logic                accept,
  input  logic                in_cmd,
  input  logic signed [11:0]  in_temp_sixteenths,
  input  logic                in_sample_valid,
  output logic                q_push,
  output sfb_pkg::job_t       q_job
);

  logic [2:0] count_r;
  logic [2:0] slot_r, slot_nxt;
  logic [2:0] len_r, len_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic       open_r, open_nxt;

  logic [2:0] cnt_sat;
  logic [7:0] hdr_crc;
  logic [7:0] value;
  logic [7:0] val_crc;
  logic [11:0] diff;
  logic [2:0] slot_inc;
  logic       slot_last;

  always_comb begin
    cnt_sat = (32'(count_r) > sfb_pkg::MaxSlots) ? 3'(sfb_pkg::MaxSlots) : count_r;
    hdr_crc = sfb_pkg::crc8_byte(sfb_pkg::CrcInit, {5'd0, cnt_sat});
    diff = in_temp_sixteenths - sfb_pkg::LowLimit;
    if (in_sample_valid && in_temp_sixteenths > sfb_pkg::LowLimit
        && in_temp_sixteenths < sfb_pkg::HighLimit) begin
      value = diff[10:3];
    end else begin
      value = 8'd0;
    end
    val_crc = sfb_pkg::crc8_byte(crc_r, value);
    slot_inc = slot_r + 3'd1;
    slot_last = (slot_inc >= len_r);
  end

  always_comb begin
    slot_nxt = slot_r;
    len_nxt = len_r;
    crc_nxt = crc_r;
    open_nxt = open_r;
    q_push = 1'b0;
    q_job.first_byte = value;
    q_job.first_kind = sfb_pkg::KindValue;
    q_job.has_crc = slot_last;
    q_job.crc_byte = val_crc;
    if (accept) begin
      case (sfb_pkg::cmd_t'(in_cmd))
        sfb_pkg::CmdStart: begin
          len_nxt = cnt_sat;
          slot_nxt = 3'd0;
          crc_nxt = hdr_crc;
          open_nxt = (cnt_sat != 3'd0);
          q_push = 1'b1;
          q_job.first_byte = {5'd0, cnt_sat};
          q_job.first_kind = sfb_pkg::KindHeader;
          q_job.has_crc = (cnt_sat == 3'd0);
          q_job.crc_byte = hdr_crc;
        end
        sfb_pkg::CmdSlot: begin
          if (!open_r || slot_r >= len_r) begin
            open_nxt = 1'b0;
          end else begin
            q_push = 1'b1;
            crc_nxt = val_crc;
            slot_nxt = slot_inc;
            open_nxt = !slot_last;
          end
        end
        default: begin
          open_nxt = open_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 3'd0;
      slot_r <= 3'd0;
      len_r <= 3'd0;
      crc_r <= sfb_pkg::CrcInit;
      open_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_sensor_count;
      end
      slot_r <= slot_nxt;
      len_r <= len_nxt;
      crc_r <= crc_nxt;
      open_r <= open_nxt;
    end
  end

`ifndef SYNTHESIS
  a_open_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (slot_r < len_r))
    else $error("open frame with slot index past its length");
  a_len_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    32'(len_r) <= sfb_pkg::MaxSlots)
    else $error("frame length above slot limit");
`endif

endmodule

// ===== hdl/sfb_queue.sv =====
// sfb_queue: short job queue between the front and back parts
// depends on sfb_pkg
module sfb_queue #(
  parameter int Depth = sfb_pkg::QDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sfb_pkg::job_t wr_job,
  input  logic          pop,
  output sfb_pkg::job_t rd_job,
  output logic          full,
  output logic          empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sfb_pkg::job_t jobs [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic do_push, do_pop;

  assign full = (count_r == CntW'(Depth));
  assign empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rd_job = jobs[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      jobs[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10: count_r <= count_r + CntW'(1);
        2'b01: count_r <= count_r - CntW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= Depth)
    else $error("queue count above depth");
`endif

endmodule

// ===== hdl/sfb_back.sv =====
// sfb_back: drains jobs and emits one or two frame bytes each through an output register
// depends on sfb_pkg
module sfb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  sfb_pkg::job_t q_job,
  input  logic          q_empty,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_frame_byte,
  output logic [1:0]    out_byte_kind,
  output logic          out_last_byte
);

  logic               valid_r;
  logic [7:0]         byte_r;
  sfb_pkg::byte_kind_t kind_r;
  logic               last_r;
  logic               pend_r;
  logic [7:0]         pend_crc_r;
  logic               slot_free;

  assign empty = !valid_r;
  assign out_frame_byte = byte_r;
  assign out_byte_kind = 2'(kind_r);
  assign out_last_byte = last_r;
  assign slot_free = !valid_r || pop;
  assign q_pop = slot_free && !pend_r && !q_empty;

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_r) begin
        byte_r <= pend_crc_r;
        kind_r <= sfb_pkg::KindCrc;
        last_r <= 1'b1;
      end else if (!q_empty) begin
        byte_r <= q_job.first_byte;
        kind_r <= q_job.first_kind;
        last_r <= 1'b0;
        pend_crc_r <= q_job.crc_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r <= 1'b0;
    end else if (slot_free) begin
      if (pend_r) begin
        valid_r <= 1'b1;
        pend_r <= 1'b0;
      end else if (!q_empty) begin
        valid_r <= 1'b1;
        pend_r <= q_job.has_crc;
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_pend_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> valid_r)
    else $error("crc byte pending with no byte shown");
  a_last_is_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && last_r) |-> (kind_r == sfb_pkg::KindCrc))
    else $error("closing byte is not a crc byte");
  a_crc_after_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && pop) |=> (valid_r && last_r))
    else $error("pending crc byte not shown next");
`endif

endmodule

// ===== hdl/sensor_frame_builder_crc8.sv =====
// sensor_frame_builder_crc8: top level of the telemetry frame builder with crc-8
// depends on sfb_pkg, sfb_front, sfb_queue, sfb_back
//
//   channel  ports                                          handshake
//   input    in_cmd, in_temp_sixteenths, in_sample_valid    push / full
//   result   out_frame_byte, out_byte_kind, out_last_byte   empty / pop
//   config   cfg_sensor_count                               cfg_we
//
// a request is taken while push is high and full is low; its zero, one or two bytes
// leave the output register at one byte per cycle while pop is high, the crc byte last
// first byte of a request passes the job queue, then the output register
// the job queue holds four requests; full rises when it fills under a stalled pop
// reset is synchronous, no clearing pass
module sensor_frame_builder_crc8 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_sensor_count,
  input  logic               push,
  output logic               full,
  input  logic               in_cmd,
  input  logic signed [11:0] in_temp_sixteenths,
  input  logic               in_sample_valid,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_frame_byte,
  output logic [1:0]         out_byte_kind,
  output logic               out_last_byte
);

  logic          accept;
  logic          q_push;
  logic          q_pop;
  logic          q_empty;
  sfb_pkg::job_t wr_job;
  sfb_pkg::job_t rd_job;

  assign accept = push && !full;

  sfb_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_sensor_count   (cfg_sensor_count),
    .accept             (accept),
    .in_cmd             (in_cmd),
    .in_temp_sixteenths (in_temp_sixteenths),
    .in_sample_valid    (in_sample_valid),
    .q_push             (q_push),
    .q_job              (wr_job)
  );

  sfb_queue #(
    .Depth (sfb_pkg::QDepth)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (wr_job),
    .pop    (q_pop),
    .rd_job (rd_job),
    .full   (full),
    .empty  (q_empty)
  );

  sfb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_job          (rd_job),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_frame_byte (out_frame_byte),
    .out_byte_kind  (out_byte_kind),
    .out_last_byte  (out_last_byte)
  );

endmodule

// ===== bench/tb_sensor_frame_builder_crc8.sv =====
`timescale 1ns / 1ps
// tb_sensor_frame_builder_crc8: self-checking bench for the crc-8 telemetry frame builder
// depends on sfb_pkg and sensor_frame_builder_crc8; runs a directed table, then random frames
// under four pacing modes, with every result byte checked against a local frame predictor
module tb_sensor_frame_builder_crc8;

  localparam int SettleCycles = 8;
  localparam int CycleLimit = 400000;
  localparam int PhaseRequests = 135;
  localparam int SenderIdle [4] = '{0, 64, 0, 31};
  localparam int RecvStall [4] = '{0, 0, 64, 31};
  localparam int PhaseCounts [8] = '{6, 0, 7, 2, 1, 5, 3, 4};

  typedef enum logic {
    OpItem = 1'b0,
    OpCfg  = 1'b1
  } row_op_t;

  typedef struct packed {
    row_op_t            op;
    sfb_pkg::cmd_t      cmd;
    logic signed [11:0] temp;
    logic               valid;
    logic [2:0]         count;
    logic               typed;
    logic [7:0]         exp_byte;
  } row_t;

  typedef struct packed {
    logic [7:0]          value;
    sfb_pkg::byte_kind_t kind;
    logic                last;
  } frame_byte_t;

  // directed table: typed bytes are the first result of the row
  localparam row_t Plan [26] = '{
    '{OpItem, sfb_pkg::CmdStart, 12'sd0, 1'b0, 3'd0, 1'b1, 8'd0},
    '{OpItem, sfb_pkg::CmdSlot, 12'sd500, 1'b1, 3'd0, 1'b0, 8'd0},
    '{OpCfg, sfb_pkg::CmdStart, 12'sd0, 1'b0, 3'd7, 1'b0, 8'd0},
    '{OpItem, sfb_pkg::CmdStart, 12'sd0, 1'b0, 3'd0, 1'b1, 8'd6},
    '{OpItem, sfb_pkg::CmdSlot, 12'sd160, 1'b1, 3'd0, 1'b1, 8'd0},
    '{OpItem, sfb_pkg::CmdSlot, 12'sd161, 1'b1, 3'd0, 1'b1, 8'd0},
    '{OpItem, sfb_pkg::CmdSlot, 12'sd168, 1'b1, 3'd0, 1'b1, 8'd1},
    '{OpItem, sfb_pkg::CmdSlot, 12'sd1599, 1'b1, 3'd0, 1'b1, 8'd179},
    '{OpItem, sfb_pkg::CmdSlot, 12'sd1600, 1'b1, 3'd0, 1'b1, 8'd0},
    '{OpItem, sfb_pkg::CmdSlot, 12'sd1000, 1'b0, 3'd0, 1'b1, 8'd0},
    '{OpItem, sfb_pkg::CmdSlot, 12'sd800, 1'b1, 3'd0, 1'b0, 8'd0},
    '{OpCfg, sfb_pkg::CmdStart, 12'sd0, 1'b0, 3'd1, 1'b0, 8'd0},
    '{OpItem, sfb_pkg::CmdStart, 12'sd0, 1'b0, 3'd0, 1'b1, 8'd1},
    '{OpItem, sfb_pkg::CmdSlot, -12'sd880, 1'b1, 3'd0, 1'b1, 8'd0},
    '{OpCfg, sfb_pkg::CmdStart, 12'sd0, 1'b0, 3'd3, 1'b0, 8'd0},
    '{OpItem, sfb_pkg::CmdStart, 12'sd0, 1'b0, 3'd0, 1'b1, 8'd3},
    '{OpItem, sfb_pkg::CmdSlot, 12'sd2000, 1'b1, 3'd0, 1'b1, 8'd0},
    '{OpItem, sfb_pkg::CmdStart, 12'sd0, 1'b0, 3'd0, 1'b1, 8'd3},
    '{OpItem, sfb_pkg::CmdSlot, -12'sd1, 1'b1, 3'd0, 1'b1, 8'd0},
    '{OpCfg, sfb_pkg::CmdStart, 12'sd0, 1'b0, 3'd5, 1'b0, 8'd0},
    '{OpItem, sfb_pkg::CmdSlot, 12'sd400, 1'b1, 3'd0, 1'b1, 8'd30},
    '{OpItem, sfb_pkg::CmdSlot, 12'sd1500, 1'b1, 3'd0, 1'b0, 8'd0},
    '{OpItem, sfb_pkg::CmdSlot, 12'sd900, 1'b1, 3'd0, 1'b0, 8'd0},
    '{OpItem, sfb_pkg::CmdStart, 12'sd0, 1'b0, 3'd0, 1'b1, 8'd5},
    '{OpCfg, sfb_pkg::CmdStart, 12'sd0, 1'b0, 3'd0, 1'b0, 8'd0},
    '{OpItem, sfb_pkg::CmdStart, 12'sd0, 1'b0, 3'd0, 1'b1, 8'd0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_sensor_count = 3'd0;
  logic               push = 1'b0;
  logic               full;
  logic               in_cmd = 1'b0;
  logic signed [11:0] in_temp_sixteenths = 12'sd0;
  logic               in_sample_valid = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [7:0]         out_frame_byte;
  logic [1:0]         out_byte_kind;
  logic               out_last_byte;

  // frame predictor state
  logic [2:0] count_reg = 3'd0;
  logic [2:0] slots_taken = 3'd0;
  logic [2:0] slots_in_frame = 3'd0;
  logic [7:0] crc_acc = 8'h00;
  logic       in_frame = 1'b0;
  frame_byte_t fresh [2];
  frame_byte_t awaited_bytes [$];

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int requests_taken = 0;
  int bytes_checked = 0;
  int frames_closed = 0;
  int cycle_count = 0;

  sensor_frame_builder_crc8 uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_sensor_count   (cfg_sensor_count),
    .push               (push),
    .full               (full),
    .in_cmd             (in_cmd),
    .in_temp_sixteenths (in_temp_sixteenths),
    .in_sample_valid    (in_sample_valid),
    .empty              (empty),
    .pop                (pop),
    .out_frame_byte     (out_frame_byte),
    .out_byte_kind      (out_byte_kind),
    .out_last_byte      (out_last_byte)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes still awaited", cycle_count,
               awaited_bytes.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [7:0] crc_step(logic [7:0] acc, logic [7:0] data);
    logic [7:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      r = {1'b0, r[7:1]} ^ ((r[0] ^ data[i]) ? sfb_pkg::CrcPoly : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [7:0] reading_to_byte(logic signed [11:0] t, logic ok);
    int s;
    s = int'(t);
    if (!ok || s <= int'(sfb_pkg::LowLimit) || s >= int'(sfb_pkg::HighLimit)) begin
      return 8'd0;
    end
    s = (s - int'(sfb_pkg::LowLimit)) >> 3;
    return s[7:0];
  endfunction

  function automatic logic [2:0] frame_slots(logic [2:0] c);
    return (int'(c) > sfb_pkg::MaxSlots) ? 3'(sfb_pkg::MaxSlots) : c;
  endfunction

  // fills fresh[] with the bytes one request produces, returns how many
  function automatic int build_bytes(sfb_pkg::cmd_t cmd, logic signed [11:0] t, logic ok);
    logic [7:0] v;
    int n;
    n = 0;
    if (cmd == sfb_pkg::CmdStart) begin
      slots_in_frame = frame_slots(count_reg);
      slots_taken = 3'd0;
      crc_acc = crc_step(sfb_pkg::CrcInit, {5'd0, slots_in_frame});
      fresh[n] = '{{5'd0, slots_in_frame}, sfb_pkg::KindHeader, 1'b0};
      n = n + 1;
      in_frame = (slots_in_frame != 3'd0);
      if (!in_frame) begin
        fresh[n] = '{crc_acc, sfb_pkg::KindCrc, 1'b1};
        n = n + 1;
      end
    end else if (!in_frame || slots_taken >= slots_in_frame) begin
      in_frame = 1'b0;
    end else begin
      v = reading_to_byte(t, ok);
      crc_acc = crc_step(crc_acc, v);
      fresh[n] = '{v, sfb_pkg::KindValue, 1'b0};
      n = n + 1;
      slots_taken = slots_taken + 3'd1;
      if (slots_taken >= slots_in_frame) begin
        fresh[n] = '{crc_acc, sfb_pkg::KindCrc, 1'b1};
        n = n + 1;
        in_frame = 1'b0;
      end
    end
    return n;
  endfunction

  function automatic logic signed [11:0] pick_reading();
    int t;
    if ($urandom_range(0, 99) < 60) begin
      t = $urandom_range(100, 1700);
    end else begin
      t = int'($urandom_range(0, 2880)) - 880;
    end
    return t[11:0];
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches = mismatches + 1;
  endtask

  task automatic push_req(sfb_pkg::cmd_t cmd, logic signed [11:0] t, logic ok, logic typed,
                          logic [7:0] typed_byte, output int produced);
    int n;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_cmd <= cmd;
    in_temp_sixteenths <= t;
    in_sample_valid <= ok;
    @(posedge clk);
    while (full !== 1'b0) begin
      @(posedge clk);
    end
    n = build_bytes(cmd, t, ok);
    if (typed && n > 0) begin
      fresh[0].value = typed_byte;
    end
    for (int i = 0; i < n; i++) begin
      awaited_bytes.push_back(fresh[i]);
    end
    requests_taken = requests_taken + 1;
    produced = n;
  endtask

  // sender holds off until every awaited byte is out
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (awaited_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_count(logic [2:0] value);
    cfg_we <= 1'b1;
    cfg_sensor_count <= value;
    @(posedge clk);
    count_reg = value;
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    pop <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && pop && empty === 1'b0) begin
      if (awaited_bytes.size() == 0) begin
        report_mismatch("byte with nothing awaited", int'(out_frame_byte), -1);
      end else begin
        want = awaited_bytes.pop_front();
        if (out_frame_byte !== want.value) begin
          report_mismatch("frame_byte", int'(out_frame_byte), int'(want.value));
        end
        if (out_byte_kind !== want.kind) begin
          report_mismatch("byte_kind", int'(out_byte_kind), int'(want.kind));
        end
        if (out_last_byte !== want.last) begin
          report_mismatch("last_byte", int'(out_last_byte), int'(want.last));
        end
        bytes_checked <= bytes_checked + 1;
        if (want.last) begin
          frames_closed <= frames_closed + 1;
        end
      end
    end
  end

  initial begin
    int n;
    int phase_reqs;
    int lim;
    int slots;
    int r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(Plan); i++) begin
      if (Plan[i].op == OpCfg) begin
        settle();
        write_count(Plan[i].count);
      end else begin
        push_req(Plan[i].cmd, Plan[i].temp, Plan[i].valid, Plan[i].typed,
                 Plan[i].exp_byte, n);
      end
    end

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      write_count(PhaseCounts[phase][2:0]);
      sender_idle_pct = SenderIdle[phase % 4];
      recv_stall_pct = RecvStall[phase % 4];
      phase_reqs = 0;
      while (phase_reqs < PhaseRequests) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          // stray slot request
          push_req(sfb_pkg::CmdSlot, pick_reading(), $urandom_range(0, 99) < 85, 1'b0,
                   8'd0, n);
          if (n > 0) phase_reqs++;
        end else begin
          push_req(sfb_pkg::CmdStart, pick_reading(), $urandom_range(0, 1) == 1, 1'b0,
                   8'd0, n);
          phase_reqs++;
          lim = int'(frame_slots(count_reg));
          r = $urandom_range(0, 99);
          if (r < 75) begin
            slots = lim;
          end else if (r < 88) begin
            slots = $urandom_range(0, lim);
          end else begin
            slots = lim + $urandom_range(1, 2);
          end
          for (int k = 0; k < slots; k++) begin
            push_req(sfb_pkg::CmdSlot, pick_reading(), $urandom_range(0, 99) < 85, 1'b0,
                     8'd0, n);
            if (n > 0) phase_reqs++;
          end
        end
      end
    end

    settle();
    $display("covered %0d requests and %0d checked bytes, %0d frames closed by a crc byte",
             requests_taken, bytes_checked, frames_closed);
    $display("counts 0 to 7 with saturation, aborted and overlong frames, four pacing modes");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
